FILE: rtl/bsu_pkg.sv
// ----------------------------------------------------------------------------
// Bucket sort package
// Shared constants, the sequencer state type and the cell control struct.
// ----------------------------------------------------------------------------
package bsu_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 16;
    localparam int SAMPLE_W       = 16;

    typedef enum logic
    {
        ST_LOAD,
        ST_DRAIN
    } bsu_state_t;

    // Operation applied to every cell of the chain in the same cycle.
    typedef struct packed
    {
        logic load;
        logic shift;
    } bsu_ctl_t;

endpackage

FILE: rtl/bucket_sort_unit_interval.sv
// ----------------------------------------------------------------------------
// Bucket sort of unit-interval fractions
// Usage:
//   The slave channel takes a batch of 0.16 fixed-point fractions, one per
//   transaction, with s_tlast on the final one. Each value is inserted into
//   a row of CAPACITY sorting cells in the cycle it arrives, so the load
//   runs at one transaction per cycle. Bucket order equals value order, so
//   the row holds the batch in ascending order at all times.
//   Values past CAPACITY are dropped and flagged in m_tuser for the batch.
//   After the s_tlast transaction the row drains from cell zero on the
//   master channel: the first result is valid in the next cycle and then
//   one result per cycle while m_tready is high, m_tlast on the last.
//   The row shifts one cell per accepted result; the slave channel is
//   held off (s_tready low) until the last result leaves.
//   If the receiver stalls, the row holds and the head value stays stable.
//   Reset empties the row and leaves the block ready for a new batch.
// ----------------------------------------------------------------------------
module bucket_sort_unit_interval
    import bsu_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_value
    input  logic                s_tlast,   // batch_end
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] sorted_value
    output logic                m_tlast,   // final_result
    output logic [0:0]          m_tuser    // [0] capacity_exceeded
);

    localparam int STORE_W = (VALUE_BITS < SAMPLE_W) ? VALUE_BITS : SAMPLE_W;

    bsu_state_t   state_reg;
    bsu_state_t   state_next;
    logic         dropped_reg;
    logic         dropped_next;
    bsu_ctl_t     ctl;

    logic [STORE_W-1:0] new_value;
    logic [STORE_W-1:0] cell_value  [CAPACITY];
    logic               cell_valid  [CAPACITY];
    logic               cell_before [CAPACITY];

    assign new_value = s_tdata[STORE_W-1:0];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [STORE_W-1:0] prev_value;
        logic               prev_valid;
        logic               prev_before;
        logic [STORE_W-1:0] next_value;
        logic               next_valid;

        if (i == 0)
        begin : g_head
            assign prev_value  = '0;
            assign prev_valid  = 1'b0;
            assign prev_before = 1'b0;
        end
        else
        begin : g_body
            assign prev_value  = cell_value[i-1];
            assign prev_valid  = cell_valid[i-1];
            assign prev_before = cell_before[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_value = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_inner
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
        end

        bsu_cell #(
            .W (STORE_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_value   (new_value),
            .prev_value  (prev_value),
            .prev_valid  (prev_valid),
            .prev_before (prev_before),
            .next_value  (next_value),
            .next_valid  (next_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .ahead       (cell_before[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        dropped_next = dropped_reg;
        ctl          = '0;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    // A full row means the last cell is occupied.
                    if (cell_valid[CAPACITY-1])
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctl.load = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                m_tvalid = cell_valid[0];
                if (cell_valid[0] && m_tready)
                begin
                    ctl.shift = 1'b1;
                    if (m_tlast)
                    begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign m_tdata    = SAMPLE_W'(cell_value[0]);
    assign m_tlast    = !cell_valid[1];
    assign m_tuser[0] = dropped_reg;

endmodule

FILE: rtl/bsu_cell.sv
// ----------------------------------------------------------------------------
// Bucket sort cell
// One slot of the sorted chain. On a load it either keeps its value, takes
// the new value, or takes its lower neighbor's value; on a shift it takes
// its upper neighbor's value so the chain drains from cell zero.
// ----------------------------------------------------------------------------
module bsu_cell
    import bsu_pkg::*;
#(
    parameter int W = VALUE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  bsu_ctl_t     ctl,
    input  logic [W-1:0] new_value,
    input  logic [W-1:0] prev_value,
    input  logic         prev_valid,
    input  logic         prev_before,
    input  logic [W-1:0] next_value,
    input  logic         next_valid,
    output logic [W-1:0] value,
    output logic         valid,
    output logic         ahead
);

    logic [W-1:0] value_reg;
    logic [W-1:0] value_next;
    logic         valid_reg;
    logic         valid_next;

    // The new value belongs in front of this cell's value (or in this empty slot).
    assign ahead = !valid_reg || (new_value < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.load && ahead)
        begin
            if (prev_before)
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
        else if (ctl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

FILE: rtl/bsu_checker.sv
// ----------------------------------------------------------------------------
// Bucket sort port checker
// Watches the top-level ports for ordering, stall stability and load/drain sequencing.
// ----------------------------------------------------------------------------
module bsu_checker
    import bsu_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata,
    input logic                m_tlast,
    input logic [0:0]          m_tuser
);

    // A stalled result keeps its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // Loading and draining never overlap.
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while results pending");

    // The end of a batch starts the drain in the next cycle.
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid && !s_tready)
        else $error("drain did not start after batch end");

    // Results come out in ascending order within a batch.
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata >= $past(m_tdata)))
        else $error("results out of order");

    // After the final result the block is ready for the next batch.
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("block not ready after final result");

endmodule

bind bucket_sort_unit_interval bsu_checker u_bsu_checker (.*);
